// ===== src/cents_to_currency_text_unit_assert.svh =====
// Assertion macros for the currency text unit.
`ifndef CENTS_TO_CURRENCY_TEXT_UNIT_ASSERT_SVH
`define CENTS_TO_CURRENCY_TEXT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define C2T_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define C2T_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/c2t_pkg.sv =====
package c2t_pkg;

    localparam int unsigned IN_W      = 64;
    localparam int unsigned MAG_BITS  = 60;
    localparam int unsigned BCD_DIGS  = 18;
    localparam int unsigned DOL_DIGS  = 16;
    localparam int unsigned BCD_W     = BCD_DIGS * 4;
    localparam int unsigned CHAR_W    = 7;

    localparam logic [IN_W-1:0] MAX_CENTS = 64'd999999999999999999;
    localparam logic [5:0]      CONV_LAST = 6'(MAG_BITS - 1);

    localparam logic [CHAR_W-1:0] CH_MINUS  = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 7'h24;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 7'h2C;
    localparam logic [CHAR_W-1:0] CH_POINT  = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NUL    = 7'h00;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CONV,
        S_SCAN,
        S_SIGN,
        S_DOLLAR,
        S_DIGIT,
        S_COMMA,
        S_POINT,
        S_CENT_HI,
        S_CENT_LO,
        S_BIG
    } t_state;

    typedef enum logic [2:0] {
        CK_MINUS,
        CK_DOLLAR,
        CK_DIGIT,
        CK_COMMA,
        CK_POINT,
        CK_CENT_HI,
        CK_CENT_LO,
        CK_BIG
    } t_char_kind;

    typedef struct packed {
        logic       load;
        logic       conv_init;
        logic       conv_step;
        logic       scan;
        logic       emit;
        t_char_kind kind;
        logic       idx_dec;
    } t_dp_cmd;

    typedef struct packed {
        logic neg;
        logic too_large;
        logic conv_last;
        logic idx_zero;
        logic idx_group;
        logic emit_ok;
    } t_dp_stat;

    // add-3 step of shift-and-add-3 on every BCD digit
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = v;
        for (int i = 0; i < BCD_DIGS; i++) begin
            if (v[i*4 +: 4] > 4'd4) begin
                r[i*4 +: 4] = v[i*4 +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    // comma follows this dollar digit
    function automatic logic is_group(input logic [3:0] idx);
        logic g;
        unique case (idx)
            4'd3, 4'd6, 4'd9, 4'd12, 4'd15: g = 1'b1;
            default:                        g = 1'b0;
        endcase
        return g;
    endfunction

endpackage

// ===== src/c2t_dp.sv =====
module c2t_dp
    import c2t_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [IN_W-1:0]   i_data,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_too_large,
    output logic              o_last
);

    logic              r_neg;
    logic [IN_W-1:0]   r_mag;
    logic [BCD_W-1:0]  r_bcd;
    logic [5:0]        r_cnt;
    logic [3:0]        r_idx;
    logic              r_m_tvalid;
    logic [CHAR_W-1:0] r_char;
    logic              r_too_large;
    logic              r_last;

    logic [4:0]        w_dpos;
    logic [3:0]        w_digit;
    logic [3:0]        w_top;
    logic              w_emit_ok;
    logic [BCD_W-1:0]  w_bcd_adj;
    logic [CHAR_W-1:0] n_char;

    assign w_dpos    = {1'b0, r_idx} + 5'd2;
    assign w_digit   = r_bcd[{w_dpos, 2'b00} +: 4];
    assign w_emit_ok = !r_m_tvalid || i_m_tready;
    assign w_bcd_adj = bcd_adjust(r_bcd);

    always_comb begin
        w_top = 4'd0;
        for (int i = 0; i < DOL_DIGS; i++) begin
            if (r_bcd[(i+2)*4 +: 4] != 4'd0) begin
                w_top = 4'(i);
            end
        end
    end

    always_comb begin
        unique case (i_cmd.kind)
            CK_MINUS:   n_char = CH_MINUS;
            CK_DOLLAR:  n_char = CH_DOLLAR;
            CK_DIGIT:   n_char = CH_ZERO + {3'b000, w_digit};
            CK_COMMA:   n_char = CH_COMMA;
            CK_POINT:   n_char = CH_POINT;
            CK_CENT_HI: n_char = CH_ZERO + {3'b000, r_bcd[7:4]};
            CK_CENT_LO: n_char = CH_ZERO + {3'b000, r_bcd[3:0]};
            CK_BIG:     n_char = CH_NUL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_data[IN_W-1];
            r_mag <= i_data[IN_W-1] ? (64'd0 - i_data) : i_data;
        end else if (i_cmd.conv_step) begin
            r_mag <= {r_mag[IN_W-2:0], 1'b0};
        end
        if (i_cmd.conv_init) begin
            r_bcd <= '0;
            r_cnt <= '0;
        end else if (i_cmd.conv_step) begin
            r_bcd <= {w_bcd_adj[BCD_W-2:0], r_mag[MAG_BITS-1]};
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_cmd.scan) begin
            r_idx <= w_top;
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - 4'd1;
        end
        if (i_cmd.emit) begin
            r_char      <= n_char;
            r_too_large <= (i_cmd.kind == CK_BIG);
            r_last      <= (i_cmd.kind == CK_BIG) || (i_cmd.kind == CK_CENT_LO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    assign o_stat.neg       = r_neg;
    assign o_stat.too_large = (r_mag > MAX_CENTS);
    assign o_stat.conv_last = (r_cnt == CONV_LAST);
    assign o_stat.idx_zero  = (r_idx == 4'd0);
    assign o_stat.idx_group = is_group(r_idx);
    assign o_stat.emit_ok   = w_emit_ok;

    assign o_m_tvalid  = r_m_tvalid;
    assign o_char      = r_char;
    assign o_too_large = r_too_large;
    assign o_last      = r_last;

endmodule

// ===== src/c2t_ctrl.sv =====
module c2t_ctrl
    import c2t_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_s_tvalid) n_state = S_CHECK;
            S_CHECK:   n_state = i_stat.too_large ? S_BIG : S_CONV;
            S_CONV:    if (i_stat.conv_last) n_state = S_SCAN;
            S_SCAN:    n_state = i_stat.neg ? S_SIGN : S_DOLLAR;
            S_SIGN:    if (i_stat.emit_ok) n_state = S_DOLLAR;
            S_DOLLAR:  if (i_stat.emit_ok) n_state = S_DIGIT;
            S_DIGIT: begin
                if (i_stat.emit_ok) begin
                    priority if (i_stat.idx_zero) begin
                        n_state = S_POINT;
                    end else if (i_stat.idx_group) begin
                        n_state = S_COMMA;
                    end else begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_COMMA:   if (i_stat.emit_ok) n_state = S_DIGIT;
            S_POINT:   if (i_stat.emit_ok) n_state = S_CENT_HI;
            S_CENT_HI: if (i_stat.emit_ok) n_state = S_CENT_LO;
            S_CENT_LO: if (i_stat.emit_ok) n_state = S_IDLE;
            S_BIG:     if (i_stat.emit_ok) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = CK_DIGIT;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_CHECK:   o_cmd.conv_init = !i_stat.too_large;
            S_CONV:    o_cmd.conv_step = 1'b1;
            S_SCAN:    o_cmd.scan = 1'b1;
            S_SIGN: begin
                o_cmd.emit = i_stat.emit_ok;
                o_cmd.kind = CK_MINUS;
            end
            S_DOLLAR: begin
                o_cmd.emit = i_stat.emit_ok;
                o_cmd.kind = CK_DOLLAR;
            end
            S_DIGIT: begin
                o_cmd.emit    = i_stat.emit_ok;
                o_cmd.kind    = CK_DIGIT;
                o_cmd.idx_dec = i_stat.emit_ok && !i_stat.idx_zero && !i_stat.idx_group;
            end
            S_COMMA: begin
                o_cmd.emit    = i_stat.emit_ok;
                o_cmd.kind    = CK_COMMA;
                o_cmd.idx_dec = i_stat.emit_ok;
            end
            S_POINT: begin
                o_cmd.emit = i_stat.emit_ok;
                o_cmd.kind = CK_POINT;
            end
            S_CENT_HI: begin
                o_cmd.emit = i_stat.emit_ok;
                o_cmd.kind = CK_CENT_HI;
            end
            S_CENT_LO: begin
                o_cmd.emit = i_stat.emit_ok;
                o_cmd.kind = CK_CENT_LO;
            end
            S_BIG: begin
                o_cmd.emit = i_stat.emit_ok;
                o_cmd.kind = CK_BIG;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== src/cents_to_currency_text_unit.sv =====
// Sequence: take the magnitude, one range check, 60 shift-and-add-3 steps,
// one leading-digit scan, then one character per cycle while the output is not stalled.
// Each amount gives N = 5..26 characters; an out-of-range amount gives a single NUL.
// No new amount is taken until the controller is back in idle after the last character.
// Reset: i_rst_n synchronous active low; clears the controller state and output valid.
`include "cents_to_currency_text_unit_assert.svh"

module cents_to_currency_text_unit
    import c2t_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] amount_cents
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] char_code, [7] zero
    output logic        o_m_tuser,   // [0] too_large
    output logic        o_m_tlast
);

    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [CHAR_W-1:0] w_char;

    c2t_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    c2t_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_data      (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_char      (w_char),
        .o_too_large (o_m_tuser),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_char};

    // out-of-range beat is a single NUL with last
    `C2T_ASSERT_IMPLY(a_big_beat, i_clk, i_rst_n, o_m_tvalid && o_m_tuser,
        o_m_tlast && (o_m_tdata == 8'h00), "too-large beat not a lone NUL")
    // one amount in flight
    `C2T_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
        !o_s_tready, "input taken while busy")
    // text always ends on a cent digit
    `C2T_ASSERT_IMPLY(a_last_digit, i_clk, i_rst_n, o_m_tvalid && o_m_tlast && !o_m_tuser,
        (o_m_tdata >= 8'h30) && (o_m_tdata <= 8'h39), "last beat not a digit")

endmodule
